@@ sv/planar_block_to_packed_tiles_assert.svh @@
// Assertion macros shared by the planar-to-packed tile converter RTL.
`ifndef PLANAR_BLOCK_TO_PACKED_TILES_ASSERT_SVH
`define PLANAR_BLOCK_TO_PACKED_TILES_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PBPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbpt: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PBPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbpt: next-cycle check failed");

`endif

@@ sv/pbpt_pkg.sv @@
// Types, constants and pixel packing for the planar-to-packed tile converter.
package pbpt_pkg;

  // Block geometry
  localparam int unsigned RowIdxW   = 4;   // 16 rows per block
  localparam int unsigned TileRowW  = 3;   // 8 rows per tile
  localparam int unsigned WordCntW  = 4;   // 16 words per output run
  localparam int unsigned PlaneW    = 8;
  localparam int unsigned HalfW     = 32;  // eight 4-bit pixels
  localparam int unsigned RowW      = 2 * HalfW;
  localparam int unsigned NumRows   = 2 ** RowIdxW;

  localparam logic [TileRowW-1:0] TileRowLast = '1;
  localparam logic [WordCntW-1:0] WordCntLast = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_e;

  // Four plane bytes to eight packed nibbles; bit 7 is pixel 0 (low nibble).
  function automatic logic [HalfW-1:0] pack_half(
    input logic [PlaneW-1:0] p0,
    input logic [PlaneW-1:0] p1,
    input logic [PlaneW-1:0] p2,
    input logic [PlaneW-1:0] p3
  );
    logic [HalfW-1:0] word;
    word = '0;
    for (int x = 0; x < 8; x++) begin
      word[4*x +: 4] = {p3[7-x], p2[7-x], p1[7-x], p0[7-x]};
    end
    return word;
  endfunction

endpackage

@@ sv/planar_block_to_packed_tiles.sv @@
// Planar 16x16 block rows in, packed 4-bit tile rows out.
// A row that is not the eighth of its half is stored and the block is ready
// again on the next cycle. The eighth row starts a readout of 16 words; each
// word is fetched from the row store (ST_READ), then held on the output
// (ST_SHOW) until taken, so output stalls lengthen the run and no rows are
// accepted until the run ends. Reset (async, active low) clears the
// sequencer and the row counter; row store contents are undefined until written.
module planar_block_to_packed_tiles (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pbpt_pkg::PlaneW-1:0] left_plane0_i,
  input  logic [pbpt_pkg::PlaneW-1:0] left_plane1_i,
  input  logic [pbpt_pkg::PlaneW-1:0] left_plane2_i,
  input  logic [pbpt_pkg::PlaneW-1:0] left_plane3_i,
  input  logic [pbpt_pkg::PlaneW-1:0] right_plane0_i,
  input  logic [pbpt_pkg::PlaneW-1:0] right_plane1_i,
  input  logic [pbpt_pkg::PlaneW-1:0] right_plane2_i,
  input  logic [pbpt_pkg::PlaneW-1:0] right_plane3_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pbpt_pkg::HalfW-1:0] tile_word_o,
  output logic [1:0]                 tile_number_o,
  output logic [pbpt_pkg::TileRowW-1:0] row_in_tile_o,
  output logic                       last_o
);
  import pbpt_pkg::*;

  `include "planar_block_to_packed_tiles_assert.svh"

  state_e                state_q, state_d;
  logic [RowIdxW-1:0]    row_q, row_d;
  logic [WordCntW-1:0]   cnt_q, cnt_d;
  logic                  base_q, base_d;
  logic [RowW-1:0]       rd_q;
  logic [RowW-1:0]       mem [NumRows];
  logic [RowW-1:0]       wr_row;
  logic [RowIdxW-1:0]    rd_addr;
  logic                  in_req, out_req, half_done;

  assign in_req    = in_valid_i && in_ready_o;
  assign out_req   = out_valid_o && out_ready_i;
  assign half_done = (row_q[TileRowW-1:0] == TileRowLast);

  // Converted row: right half in the upper word
  assign wr_row = {pack_half(right_plane0_i, right_plane1_i, right_plane2_i, right_plane3_i),
                   pack_half(left_plane0_i, left_plane1_i, left_plane2_i, left_plane3_i)};

  // Readout address: half of block, then tile row
  assign rd_addr = {base_q, cnt_q[TileRowW-1:0]};

  // Row store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      mem[row_q] <= wr_row;
    end
    if (state_q == ST_READ) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          row_d = row_q + 1'b1;
          if (half_done) begin
            state_d = ST_READ;
            cnt_d   = '0;
            base_d  = row_q[RowIdxW-1];
          end
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_req) begin
          if (cnt_q == WordCntLast) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_SHOW: out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    // Upper word counter bit picks the right tile
    tile_word_o   = cnt_q[WordCntW-1] ? rd_q[RowW-1:HalfW] : rd_q[HalfW-1:0];
    tile_number_o = {base_q, cnt_q[WordCntW-1]};
    row_in_tile_o = cnt_q[TileRowW-1:0];
    last_o        = (cnt_q == WordCntLast);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      cnt_q   <= '0;
      base_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
    end
  end

  // Checks
  `PBPT_ASSERT_IMPL(a_no_overlap, in_ready_o, !out_valid_o)
  `PBPT_ASSERT_NEXT(a_half_starts_run, in_req && half_done, state_q == ST_READ && cnt_q == '0)
  `PBPT_ASSERT_NEXT(a_plain_row_ready, in_req && !half_done, in_ready_o)
  `PBPT_ASSERT_NEXT(a_last_ends_run, out_req && last_o, in_ready_o)
  `PBPT_ASSERT_NEXT(a_word_refetch, out_req && !last_o, !out_valid_o && !in_ready_o)

endmodule
